/* hw/rtl/npd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npd_pkg
// Shared types and constants for the nearest point distance level block.
// ----------------------------------------------------------------------------
package npd_pkg;

    localparam int PIU_W      = 5;
    localparam int BAND_W     = 8;
    localparam int LVL_W      = 4;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 2 * (BAND_W + LVL_W);

    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL     = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [PIU_W-1:0]  PIU_RESET  = 5'd4;
    localparam logic [BAND_W-1:0] BAND_RESET = 8'd10;
    localparam logic [LVL_W-1:0]  MAXL_RESET = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_LEVEL = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

endpackage : npd_pkg
`default_nettype wire

/* hw/rtl/npd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : npd_ram
`default_nettype wire

/* hw/rtl/npd_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npd_scan
// Walks the point table one entry per cycle and keeps the smallest squared
// distance; lowest index wins on ties.
// ----------------------------------------------------------------------------
module npd_scan
    import npd_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int SLOT_BITS  = 4,
    parameter int DIST_BITS  = 2 * COORD_BITS + 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [SLOT_BITS-1:0]    n_last,
    input  wire logic [COORD_BITS-1:0]   qx,
    input  wire logic [COORD_BITS-1:0]   qy,
    output logic                         rd_en,
    output logic      [SLOT_BITS-1:0]    rd_addr,
    input  wire logic [2*COORD_BITS-1:0] rd_data,
    output logic                         done,
    output logic      [DIST_BITS-1:0]    best_d,
    output logic      [SLOT_BITS-1:0]    best_idx
);

    logic                    issuing_reg;
    logic [SLOT_BITS-1:0]    cnt_reg;
    logic                    v1_reg, last1_reg;
    logic [SLOT_BITS-1:0]    idx1_reg;
    logic                    v2_reg, last2_reg;
    logic [SLOT_BITS-1:0]    idx2_reg;
    logic [2*COORD_BITS-1:0] sqx_reg, sqy_reg;
    logic                    done_reg;
    logic [DIST_BITS-1:0]    best_d_reg;
    logic [SLOT_BITS-1:0]    best_idx_reg;

    logic [COORD_BITS-1:0]   px, py, dx, dy;
    logic [DIST_BITS-1:0]    d_sum;

    assign rd_en   = issuing_reg;
    assign rd_addr = cnt_reg;

    assign px = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign py = rd_data[COORD_BITS-1:0];
    assign dx = (px >= qx) ? (px - qx) : (qx - px);
    assign dy = (py >= qy) ? (py - qy) : (qy - py);
    assign d_sum = DIST_BITS'(sqx_reg) + DIST_BITS'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            cnt_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                issuing_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (issuing_reg)
            begin
                if (cnt_reg == n_last)
                begin
                    issuing_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            v1_reg   <= issuing_reg;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg && last2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= cnt_reg;
        last1_reg <= (cnt_reg == n_last);
        idx2_reg  <= idx1_reg;
        last2_reg <= last1_reg;
        sqx_reg   <= dx * dx;
        sqy_reg   <= dy * dy;
        if (v2_reg && ((idx2_reg == '0) || (d_sum < best_d_reg)))
        begin
            best_d_reg   <= d_sum;
            best_idx_reg <= idx2_reg;
        end
    end

    assign done     = done_reg;
    assign best_d   = best_d_reg;
    assign best_idx = best_idx_reg;

endmodule : npd_scan
`default_nettype wire

/* hw/rtl/npd_level.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npd_level
// Steps through level thresholds (band_width*k)^2, built up by adds, one
// threshold per cycle, and keeps the largest k, up to max_level, whose threshold is not above the distance.
// ----------------------------------------------------------------------------
module npd_level
    import npd_pkg::*;
#(
    parameter int DIST_BITS = 21
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIST_BITS-1:0] best_d,
    input  wire logic [BAND_W-1:0]    band_width,
    input  wire logic [LVL_W-1:0]     max_level,
    output logic                      done,
    output logic      [LVL_W-1:0]     level
);

    localparam int CMP_W = (DIST_BITS > SQ_W) ? DIST_BITS : SQ_W;

    logic              busy_reg;
    logic [LVL_W-1:0]  k_reg, lvl_reg;
    logic [SQ_W-1:0]   sq_reg, inc_reg, bsq_reg;
    logic              hit, finish;

    assign hit    = (CMP_W'(sq_reg) <= CMP_W'(best_d)) && (max_level != '0);
    assign finish = !hit || (k_reg == max_level);
    assign done   = busy_reg && finish;
    assign level  = lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        bsq_reg <= SQ_W'(band_width) * SQ_W'(band_width);
        if (start)
        begin
            k_reg   <= {{(LVL_W-1){1'b0}}, 1'b1};
            lvl_reg <= '0;
            sq_reg  <= bsq_reg;
            inc_reg <= bsq_reg;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                lvl_reg <= k_reg;
            end
            k_reg   <= k_reg + 1'b1;
            inc_reg <= inc_reg + {bsq_reg[SQ_W-2:0], 1'b0};
            sq_reg  <= sq_reg + inc_reg + {bsq_reg[SQ_W-2:0], 1'b0};
        end
    end

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (max_level != '0) |-> (k_reg <= max_level))
        else $error("level step beyond max_level");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start |=> !busy_reg)
        else $error("level stepper still busy after done");

    a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (lvl_reg < k_reg))
        else $error("level ran ahead of step counter");

endmodule : npd_level
`default_nettype wire

/* hw/rtl/nearest_point_distance_level.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_distance_level
// Finds the nearest stored reference point to a queried position and returns
// its slot and the quantized distance level.
// ----------------------------------------------------------------------------
// Write item: stored in the table RAM at the accepting edge.
// Query: the points searched are read from the table (one RAM read per cycle),
//   then the threshold steps run (one per cycle, at least one, at most
//   max_level when max_level is nonzero).
// One query at a time; the next item is taken once the result is transferred.
// Reset clears control state and loads the register defaults; table contents
//   stay undefined until written.
module nearest_point_distance_level
    import npd_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 10,
    parameter int SLOT_BITS  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [SLOT_BITS-1:0]  slot,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [LVL_W-1:0]      level,
    output logic      [SLOT_BITS-1:0]  nearest_slot,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DIST_BITS = 2 * COORD_BITS + 1;

    state_t                 state_reg, state_next;
    logic [PIU_W-1:0]       piu_reg;
    logic [BAND_W-1:0]      band_reg;
    logic [LVL_W-1:0]       maxl_reg;
    logic [COORD_BITS-1:0]  qx_reg, qy_reg;

    logic                   in_xfer, out_xfer, query_xfer, tbl_wr;
    logic [15:0]            n_full;
    logic [SLOT_BITS-1:0]   n_last;

    logic                   rd_en;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic [2*COORD_BITS-1:0] rd_data;
    logic                   scan_done, lvl_done;
    logic [DIST_BITS-1:0]   best_d;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign query_xfer = in_xfer && (op == OP_QUERY);
    assign tbl_wr     = in_xfer && (op == OP_WRITE) && (32'(slot) < MAX_POINTS);
    assign out_valid  = (state_reg == S_OUT);
    assign out_xfer   = out_valid && !out_stall;

    always_comb
    begin
        n_full = {{(16-PIU_W){1'b0}}, piu_reg};
        if (n_full == 16'd0)
        begin
            n_full = 16'd1;
        end
        if (32'(n_full) > MAX_POINTS)
        begin
            n_full = 16'(MAX_POINTS);
        end
        n_last = SLOT_BITS'(n_full - 16'd1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                if (lvl_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            piu_reg   <= PIU_RESET;
            band_reg  <= BAND_RESET;
            maxl_reg  <= MAXL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POINTS_IN_USE: piu_reg  <= cfg_data[PIU_W-1:0];
                    CFG_BAND_WIDTH:    band_reg <= cfg_data[BAND_W-1:0];
                    CFG_MAX_LEVEL:     maxl_reg <= cfg_data[LVL_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
        end
    end

    npd_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_POINTS),
        .AW    (SLOT_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (slot),
        .wr_data ({pos_x, pos_y}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    npd_scan #(
        .COORD_BITS (COORD_BITS),
        .SLOT_BITS  (SLOT_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (query_xfer),
        .n_last   (n_last),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .done     (scan_done),
        .best_d   (best_d),
        .best_idx (nearest_slot)
    );

    npd_level #(
        .DIST_BITS (DIST_BITS)
    ) u_level (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_done),
        .best_d     (best_d),
        .band_width (band_reg),
        .max_level  (maxl_reg),
        .done       (lvl_done),
        .level      (level)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !out_valid)
        else $error("input transfer while a result is pending");

    a_level_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level <= maxl_reg))
        else $error("level above max_level");

    a_out_after_level: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(lvl_done))
        else $error("result shown without finished level search");

    a_scan_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == S_SCAN))
        else $error("scan finished outside scan state");

endmodule : nearest_point_distance_level
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Regression for nearest_point_distance_level. Loads the point table, runs
// queries under several register settings (extremes included) and checks
// every returned slot and level against a local predictor. Both channels
// idle at random except in one phase; one long receiver hold forces the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import npd_pkg::*;

    localparam int NPTS         = 16;
    localparam int CBITS        = 10;
    localparam int SBITS        = 4;
    localparam int CMAX         = (1 << CBITS) - 1;
    localparam int PACE_MAX     = 17;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;

    typedef struct packed {
        logic             op;
        logic [SBITS-1:0] slot;
        logic [CBITS-1:0] x;
        logic [CBITS-1:0] y;
    } point_item_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [SBITS-1:0] slot;
    } nearest_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  op           = OP_WRITE;
    logic [SBITS-1:0]      slot         = '0;
    logic [CBITS-1:0]      pos_x        = '0;
    logic [CBITS-1:0]      pos_y        = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [LVL_W-1:0]      level;
    logic [SBITS-1:0]      nearest_slot;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_POINTS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // predictor state, updated in transfer order
    logic [CBITS-1:0] table_x [NPTS];
    logic [CBITS-1:0] table_y [NPTS];
    logic [PIU_W-1:0] shadow_points = PIU_RESET;
    logic [BAND_W-1:0] shadow_band  = BAND_RESET;
    logic [LVL_W-1:0] shadow_maxlvl = MAXL_RESET;

    // stimulus-side mirror of the table, updated in queue order
    int unsigned mirror_x [NPTS];
    int unsigned mirror_y [NPTS];

    point_item_t pending_items[$];
    nearest_t    nearest_answers[$];

    bit          idle_on      = 1'b1;
    bit          sent         = 1'b0;
    bit          got          = 1'b0;
    bit          hold_done    = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned hold_left    = 0;
    int unsigned answers_seen = 0;
    int unsigned bad_count    = 0;

    nearest_point_distance_level dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .level        (level),
        .nearest_slot (nearest_slot),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("nearest_point_distance_level regression: fail");
        $finish;
    end

    function automatic int unsigned search_count();
        int unsigned cnt;
        cnt = shadow_points;
        if (cnt == 0)
            cnt = 1;
        if (cnt > NPTS)
            cnt = NPTS;
        return cnt;
    endfunction

    function automatic void predict_nearest(input point_item_t it);
        int unsigned     idx;
        int unsigned     pick;
        int unsigned     lvl;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned dsq;
        longint unsigned best;
        longint unsigned thr;
        nearest_t        ans;
        if (it.op == OP_WRITE)
        begin
            table_x[it.slot] = it.x;
            table_y[it.slot] = it.y;
        end
        else
        begin
            pick = 0;
            best = 0;
            for (idx = 0; idx < search_count(); idx++)
            begin
                dx  = (table_x[idx] >= it.x) ? table_x[idx] - it.x : it.x - table_x[idx];
                dy  = (table_y[idx] >= it.y) ? table_y[idx] - it.y : it.y - table_y[idx];
                dsq = dx * dx + dy * dy;
                if (idx == 0 || dsq < best)
                begin
                    best = dsq;
                    pick = idx;
                end
            end
            lvl = 0;
            for (int unsigned k = 1; k <= shadow_maxlvl; k++)
            begin
                thr = longint'(shadow_band) * k;
                if (thr * thr <= best)
                    lvl = k;
                else
                    break;
            end
            ans.level = lvl[LVL_W-1:0];
            ans.slot  = pick[SBITS-1:0];
            nearest_answers.push_back(ans);
        end
    endfunction

    function automatic void queue_item(input logic op_v, input int unsigned s,
                                       input int unsigned x, input int unsigned y);
        point_item_t it;
        it.op   = op_v;
        it.slot = s[SBITS-1:0];
        it.x    = x[CBITS-1:0];
        it.y    = y[CBITS-1:0];
        if (op_v == OP_WRITE)
        begin
            mirror_x[it.slot] = it.x;
            mirror_y[it.slot] = it.y;
        end
        pending_items.push_back(it);
    endfunction

    function automatic int unsigned pick_coord();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return CMAX;
        return $urandom_range(0, CMAX);
    endfunction

    function automatic int unsigned clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > CMAX)
            return CMAX;
        return v;
    endfunction

    function automatic void add_random_item();
        int unsigned roll;
        int unsigned s;
        int          r;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            queue_item(OP_WRITE, $urandom_range(0, NPTS - 1), pick_coord(), pick_coord());
        else if (roll < 75)
        begin
            // query close to a searched point so levels spread below saturation
            s = $urandom_range(0, search_count() - 1);
            r = shadow_band * (shadow_maxlvl + 1);
            if (r > 600)
                r = 600;
            if (r < 2)
                r = 2;
            queue_item(OP_QUERY, $urandom_range(0, NPTS - 1),
                       clamp_coord(int'(mirror_x[s]) + int'($urandom_range(0, 2 * r)) - r),
                       clamp_coord(int'(mirror_y[s]) + int'($urandom_range(0, 2 * r)) - r));
        end
        else
            queue_item(OP_QUERY, $urandom_range(0, NPTS - 1), pick_coord(), pick_coord());
    endfunction

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_POINTS_IN_USE: shadow_points = data[PIU_W-1:0];
            CFG_BAND_WIDTH:    shadow_band   = data[BAND_W-1:0];
            CFG_MAX_LEVEL:     shadow_maxlvl = data[LVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || in_valid || nearest_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] set_points [PHASES];
        logic [CFG_DATA_W-1:0] set_band   [PHASES];
        logic [CFG_DATA_W-1:0] set_maxlvl [PHASES];
        set_points = '{8'd16, 8'd0,   8'hFF, 8'd1,   8'd16, 8'd0, 8'd0, 8'd0};
        set_band   = '{8'd1,  8'd255, 8'd0,  8'd255, 8'd10, 8'd0, 8'd0, 8'd0};
        set_maxlvl = '{8'd15, 8'd0,   8'd15, 8'd15,  8'd9,  8'd0, 8'd0, 8'd0};
        for (int p = 5; p < PHASES; p++)
        begin
            set_points[p] = CFG_DATA_W'($urandom_range(1, NPTS));
            set_band[p]   = CFG_DATA_W'($urandom_range(1, 255));
            set_maxlvl[p] = CFG_DATA_W'($urandom_range(0, 15));
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners, a pair of equidistant points, a duplicate pair, far points
        queue_item(OP_WRITE, 0, 0, 0);
        queue_item(OP_WRITE, 1, CMAX, CMAX);
        queue_item(OP_WRITE, 2, 0, CMAX);
        queue_item(OP_WRITE, 3, CMAX, 0);
        queue_item(OP_WRITE, 4, 100, 100);
        queue_item(OP_WRITE, 5, 300, 100);
        queue_item(OP_WRITE, 6, 500, 500);
        queue_item(OP_WRITE, 7, 500, 500);
        for (int i = 8; i < NPTS; i++)
            queue_item(OP_WRITE, i, 900 + (i - 8) * 15, 100 + (i - 8) * 110);

        // reset settings: four points, band 10, top level 9
        queue_item(OP_QUERY, 15, 0, 0);
        queue_item(OP_QUERY, 0, CMAX, CMAX);
        queue_item(OP_QUERY, 7, CMAX, 0);
        queue_item(OP_QUERY, 9, 511, 511);
        queue_item(OP_QUERY, 3, 3, 4);
        queue_item(OP_QUERY, 5, 6, 8);
        queue_item(OP_QUERY, 12, 48, 64);
        queue_item(OP_QUERY, 1, 54, 72);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            set_register(CFG_POINTS_IN_USE, set_points[p]);
            set_register(CFG_BAND_WIDTH, set_band[p]);
            set_register(CFG_MAX_LEVEL, set_maxlvl[p]);
            idle_on = (p != 2);
            if (p == 0)
            begin
                queue_item(OP_QUERY, 2, 200, 100);
                queue_item(OP_QUERY, 11, 500, 500);
                queue_item(OP_QUERY, 6, 501, 500);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                add_random_item();
            settle();
        end

        if (bad_count == 0)
            $display("nearest_point_distance_level regression: pass");
        else
            $display("nearest_point_distance_level regression: fail");
        $finish;
    end

    always @(negedge clk)
    begin : drive
        point_item_t nxt;
        if (rst_n && !(in_valid && !sent))
        begin
            if (sent)
            begin
                sent     = 1'b0;
                send_gap = idle_on ? $urandom_range(0, PACE_MAX) : 0;
            end
            if (send_gap > 0 || pending_items.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                nxt = pending_items.pop_front();
                in_valid <= 1'b1;
                op       <= nxt.op;
                slot     <= nxt.slot;
                pos_x    <= nxt.x;
                pos_y    <= nxt.y;
            end
        end
    end

    always @(negedge clk)
    begin : receive
        if (rst_n)
        begin
            if (got)
            begin
                got      = 1'b0;
                recv_gap = idle_on ? $urandom_range(0, PACE_MAX) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && answers_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : watch
        point_item_t it;
        nearest_t    want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sent    = 1'b1;
                it.op   = op;
                it.slot = slot;
                it.x    = pos_x;
                it.y    = pos_y;
                predict_nearest(it);
            end
            if (out_valid && !out_stall)
            begin
                got = 1'b1;
                answers_seen++;
                if (nearest_answers.size() == 0)
                begin
                    if (bad_count < 10)
                        $display("unexpected transfer at %0t: level %0d slot %0d",
                                 $time, level, nearest_slot);
                    bad_count++;
                end
                else
                begin
                    want = nearest_answers.pop_front();
                    if (want.level !== level || want.slot !== nearest_slot)
                    begin
                        if (bad_count < 10)
                            $display({"mismatch at %0t: expected level %0d slot %0d,",
                                      " got level %0d slot %0d"},
                                     $time, want.level, want.slot, level, nearest_slot);
                        bad_count++;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire
